### rtl/bbb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbb_pkg
// shared types, codes and helpers for the interval bellman backup block
// ----------------------------------------------------------------------------
package bbb_pkg;

  localparam int MAX_ACTIONS = 256;
  localparam int ACT_W       = 8;
  localparam int VAL_W       = 32;
  localparam int PROB_W      = 17;
  localparam int SUM_W       = 64;
  localparam int PROD_W      = 51;
  localparam int QW_W        = 52;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_IDX_W-1:0]  REG_DISCOUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_LOWER_EN    = 1'b1;
  localparam logic [PROB_W-1:0]     DISCOUNT_RESET  = 17'd62259;
  localparam logic [ACT_W-1:0]      LAST_ACT_INDEX  = ACT_W'(MAX_ACTIONS - 1);
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  // sequencer states
  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_ML   = 13'b0000000000010,
    ST_MU   = 13'b0000000000100,
    ST_AU   = 13'b0000000001000,
    ST_SUL  = 13'b0000000010000,
    ST_SUH  = 13'b0000000100000,
    ST_SLL  = 13'b0000001000000,
    ST_SLH  = 13'b0000010000000,
    ST_LQW  = 13'b0000100000000,
    ST_LQS  = 13'b0001000000000,
    ST_UQW  = 13'b0010000000000,
    ST_UQS  = 13'b0100000000000,
    ST_EMIT = 13'b1000000000000
  } state_t;

  // multiplier operand a
  typedef enum logic [2:0] {
    MUL_NL    = 3'd0,
    MUL_NU    = 3'd1,
    MUL_SL_LO = 3'd2,
    MUL_SL_HI = 3'd3,
    MUL_SU_LO = 3'd4,
    MUL_SU_HI = 3'd5
  } mul_sel_t;

  // use of the previous cycle's product
  typedef enum logic [2:0] {
    ACC_NONE  = 3'd0,
    ACC_SUM_L = 3'd1,
    ACC_SUM_U = 3'd2,
    ACC_FRAC  = 3'd3,
    ACC_QWIDE = 3'd4
  } acc_op_t;

  typedef enum logic [1:0] {
    Q_NONE  = 2'd0,
    Q_UPPER = 2'd1,
    Q_LOWER = 2'd2
  } q_op_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    q_op_t    q_op;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic item_last;
    logic lb_on;
    logic out_free;
  } status_t;

  function automatic logic signed [SUM_W-1:0] sat_add64(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic [SUM_W:0] s;
    logic signed [SUM_W-1:0] r;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = s[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [QW_W-1:0] x);
    logic signed [VAL_W-1:0] r;
    if (x > QW_W'(VAL_MAX)) begin
      r = VAL_MAX;
    end else if (x < QW_W'(VAL_MIN)) begin
      r = VAL_MIN;
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/bbb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbb_ctrl
// sequencer: steps the shared multiplier and accumulators through one word
// ----------------------------------------------------------------------------
module bbb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             outcome_present,
  input  wire logic             last_outcome,
  output logic                  in_ready,
  input  wire bbb_pkg::status_t status,
  output bbb_pkg::cmd_t         cmd
);

  bbb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == bbb_pkg::ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.mul_sel = bbb_pkg::MUL_NL;
    cmd.acc_op  = bbb_pkg::ACC_NONE;
    cmd.q_op    = bbb_pkg::Q_NONE;
    cmd.emit    = 1'b0;
    case (state)
      bbb_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (outcome_present) begin
            state_next = status.lb_on ? bbb_pkg::ST_ML : bbb_pkg::ST_MU;
          end else if (last_outcome) begin
            state_next = bbb_pkg::ST_SUL;
          end
        end
      end
      bbb_pkg::ST_ML: begin
        cmd.mul_sel = bbb_pkg::MUL_NL;
        state_next  = bbb_pkg::ST_MU;
      end
      bbb_pkg::ST_MU: begin
        cmd.mul_sel = bbb_pkg::MUL_NU;
        cmd.acc_op  = status.lb_on ? bbb_pkg::ACC_SUM_L : bbb_pkg::ACC_NONE;
        state_next  = bbb_pkg::ST_AU;
      end
      bbb_pkg::ST_AU: begin
        cmd.acc_op = bbb_pkg::ACC_SUM_U;
        state_next = status.item_last ? bbb_pkg::ST_SUL : bbb_pkg::ST_IDLE;
      end
      bbb_pkg::ST_SUL: begin
        cmd.mul_sel = bbb_pkg::MUL_SU_LO;
        state_next  = bbb_pkg::ST_SUH;
      end
      bbb_pkg::ST_SUH: begin
        cmd.mul_sel = bbb_pkg::MUL_SU_HI;
        cmd.acc_op  = bbb_pkg::ACC_FRAC;
        state_next  = status.lb_on ? bbb_pkg::ST_SLL : bbb_pkg::ST_UQW;
      end
      bbb_pkg::ST_SLL: begin
        cmd.mul_sel = bbb_pkg::MUL_SL_LO;
        cmd.acc_op  = bbb_pkg::ACC_QWIDE;
        state_next  = bbb_pkg::ST_SLH;
      end
      bbb_pkg::ST_SLH: begin
        cmd.mul_sel = bbb_pkg::MUL_SL_HI;
        cmd.acc_op  = bbb_pkg::ACC_FRAC;
        cmd.q_op    = bbb_pkg::Q_UPPER;
        state_next  = bbb_pkg::ST_LQW;
      end
      bbb_pkg::ST_LQW: begin
        cmd.acc_op = bbb_pkg::ACC_QWIDE;
        state_next = bbb_pkg::ST_LQS;
      end
      bbb_pkg::ST_LQS: begin
        cmd.q_op   = bbb_pkg::Q_LOWER;
        state_next = bbb_pkg::ST_EMIT;
      end
      bbb_pkg::ST_UQW: begin
        cmd.acc_op = bbb_pkg::ACC_QWIDE;
        state_next = bbb_pkg::ST_UQS;
      end
      bbb_pkg::ST_UQS: begin
        cmd.q_op   = bbb_pkg::Q_UPPER;
        state_next = bbb_pkg::ST_EMIT;
      end
      bbb_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.out_free) begin
          state_next = bbb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bbb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/bbb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbb_dp
// datapath: word latch, shared multiplier, sums, q values, bests, output reg
// ----------------------------------------------------------------------------
module bbb_dp (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire bbb_pkg::cmd_t                           cmd,
  output bbb_pkg::status_t                             status,
  input  wire logic                                    cfg_write,
  input  wire logic [bbb_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [bbb_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  wire logic [bbb_pkg::PROB_W-1:0]              outcome_prob,
  input  wire logic signed [bbb_pkg::VAL_W-1:0]        next_lower,
  input  wire logic signed [bbb_pkg::VAL_W-1:0]        next_upper,
  input  wire logic                                    last_outcome,
  input  wire logic signed [bbb_pkg::VAL_W-1:0]        action_reward,
  input  wire logic                                    last_action,
  input  wire logic signed [bbb_pkg::VAL_W-1:0]        node_old_lower,
  input  wire logic signed [bbb_pkg::VAL_W-1:0]        node_old_upper,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic [bbb_pkg::ACT_W-1:0]                    action_index,
  output logic signed [bbb_pkg::VAL_W-1:0]             q_lower,
  output logic signed [bbb_pkg::VAL_W-1:0]             q_upper,
  output logic                                         node_done,
  output logic signed [bbb_pkg::VAL_W-1:0]             node_lower,
  output logic signed [bbb_pkg::VAL_W-1:0]             node_upper,
  output logic signed [bbb_pkg::ACT_W:0]               best_action
);

  // configuration
  logic [bbb_pkg::PROB_W-1:0] discount;
  logic                       lower_en;

  // latched word
  logic [bbb_pkg::PROB_W-1:0]       prob;
  logic signed [bbb_pkg::VAL_W-1:0] nl, nu, reward, old_l, old_u;
  logic                             item_last, item_last_act;

  // arithmetic state
  logic signed [bbb_pkg::PROD_W-1:0] prod;
  logic signed [bbb_pkg::SUM_W-1:0]  sum_l, sum_u;
  logic [bbb_pkg::PROB_W-1:0]        frac;
  logic signed [bbb_pkg::QW_W-1:0]   qw;
  logic signed [bbb_pkg::VAL_W-1:0]  ql, qu;
  logic signed [bbb_pkg::VAL_W-1:0]  best_l, best_u;
  logic signed [bbb_pkg::ACT_W:0]    best_act;
  logic [bbb_pkg::ACT_W-1:0]         act_cnt;

  logic signed [32:0]                 mul_a;
  logic signed [bbb_pkg::PROB_W:0]    mul_b;
  logic signed [bbb_pkg::SUM_W-1:0]   prod_ext;
  logic signed [bbb_pkg::QW_W-1:0]    qw_next;
  logic signed [bbb_pkg::VAL_W-1:0]   q_sat;
  logic                               out_free;

  assign out_free = !out_valid || out_ready;
  assign status   = '{item_last: item_last, lb_on: lower_en, out_free: out_free};

  always_ff @(posedge clk) begin
    if (rst) begin
      discount <= bbb_pkg::DISCOUNT_RESET;
      lower_en <= 1'b1;
    end else if (cfg_write) begin
      if (cfg_index == bbb_pkg::REG_DISCOUNT) begin
        discount <= cfg_data;
      end
      if (cfg_index == bbb_pkg::REG_LOWER_EN) begin
        lower_en <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prob          <= outcome_prob;
      nl            <= next_lower;
      nu            <= next_upper;
      item_last     <= last_outcome;
      reward        <= action_reward;
      item_last_act <= last_action;
      old_l         <= node_old_lower;
      old_u         <= node_old_upper;
    end
  end

  // operand select: sums split into signed high and unsigned low halves
  always_comb begin
    mul_b = {1'b0, discount};
    case (cmd.mul_sel)
      bbb_pkg::MUL_NL: begin
        mul_a = {nl[31], nl};
        mul_b = {1'b0, prob};
      end
      bbb_pkg::MUL_NU: begin
        mul_a = {nu[31], nu};
        mul_b = {1'b0, prob};
      end
      bbb_pkg::MUL_SL_LO: mul_a = {1'b0, sum_l[31:0]};
      bbb_pkg::MUL_SL_HI: mul_a = {sum_l[63], sum_l[63:32]};
      bbb_pkg::MUL_SU_LO: mul_a = {1'b0, sum_u[31:0]};
      bbb_pkg::MUL_SU_HI: mul_a = {sum_u[63], sum_u[63:32]};
      default:            mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign prod_ext = {{(bbb_pkg::SUM_W-bbb_pkg::PROD_W){prod[bbb_pkg::PROD_W-1]}}, prod};
  assign qw_next  = {prod[bbb_pkg::PROD_W-1], prod}
                  + {{(bbb_pkg::QW_W-bbb_pkg::PROB_W){1'b0}}, frac}
                  + {{(bbb_pkg::QW_W-bbb_pkg::VAL_W){reward[31]}}, reward};
  assign q_sat    = bbb_pkg::sat32(qw);

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      bbb_pkg::ACC_FRAC:  frac <= prod[48:32];
      bbb_pkg::ACC_QWIDE: qw   <= qw_next;
      default: ;
    endcase
    if (cmd.q_op == bbb_pkg::Q_UPPER) begin
      qu <= q_sat;
    end
    if (cmd.q_op == bbb_pkg::Q_LOWER) begin
      ql <= q_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_l    <= '0;
      sum_u    <= '0;
      best_l   <= bbb_pkg::VAL_MIN;
      best_u   <= bbb_pkg::VAL_MIN;
      best_act <= '1;
      act_cnt  <= '0;
    end else begin
      if (cmd.acc_op == bbb_pkg::ACC_SUM_L) begin
        sum_l <= bbb_pkg::sat_add64(sum_l, prod_ext);
      end
      if (cmd.acc_op == bbb_pkg::ACC_SUM_U) begin
        sum_u <= bbb_pkg::sat_add64(sum_u, prod_ext);
      end
      if (cmd.q_op == bbb_pkg::Q_UPPER && q_sat > best_u) begin
        best_u   <= q_sat;
        best_act <= {1'b0, act_cnt};
      end
      if (cmd.q_op == bbb_pkg::Q_LOWER && q_sat > best_l) begin
        best_l <= q_sat;
      end
      if (cmd.emit && out_free) begin
        sum_l <= '0;
        sum_u <= '0;
        if (item_last_act) begin
          best_l   <= bbb_pkg::VAL_MIN;
          best_u   <= bbb_pkg::VAL_MIN;
          best_act <= '1;
          act_cnt  <= '0;
        end else begin
          act_cnt <= (act_cnt == bbb_pkg::LAST_ACT_INDEX) ? '0 : act_cnt + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      action_index <= act_cnt;
      q_lower      <= lower_en ? ql : '0;
      q_upper      <= qu;
      node_done    <= item_last_act;
      if (item_last_act) begin
        if (lower_en) begin
          node_lower <= (old_l > best_l) ? old_l : best_l;
        end else begin
          node_lower <= old_l;
        end
        node_upper  <= (old_u < best_u) ? old_u : best_u;
        best_action <= best_act;
      end else begin
        node_lower  <= '0;
        node_upper  <= '0;
        best_action <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/bellman_bound_backup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bellman_bound_backup
// interval bellman backup for one decision node, one outcome edge per word
// ----------------------------------------------------------------------------
// Each input word is one outcome edge. A present edge adds prob*next_lower and
// prob*next_upper into two saturating 64-bit sums; on the last outcome of an
// action the sums are scaled by the discount, the reward is added, and one
// result word carries both saturated q values. On the node's last action the
// same result word also carries the new node bounds and the upper argmax.
// Everything goes through a single 33x18 multiplier with a registered product,
// stepped by a small sequencer, so one word is in flight at a time. A present
// edge adds its lower product (not with the lower bound off) and its upper
// product; a final edge then scales both sums, adds the reward and waits for
// the output register to empty; that register lets the next word be taken
// while a result still waits downstream. The user must write configuration through
// cfg_write/cfg_index/cfg_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module bellman_bound_backup (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // configuration
  input  wire logic                                    cfg_write,
  input  wire logic [bbb_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [bbb_pkg::CFG_DATA_W-1:0]          cfg_data,
  // input words
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [bbb_pkg::PROB_W-1:0]              outcome_prob,
  input  wire logic                                    outcome_present,
  input  wire logic signed [bbb_pkg::VAL_W-1:0]        next_lower,
  input  wire logic signed [bbb_pkg::VAL_W-1:0]        next_upper,
  input  wire logic                                    last_outcome,
  input  wire logic signed [bbb_pkg::VAL_W-1:0]        action_reward,
  input  wire logic                                    last_action,
  input  wire logic signed [bbb_pkg::VAL_W-1:0]        node_old_lower,
  input  wire logic signed [bbb_pkg::VAL_W-1:0]        node_old_upper,
  // result words
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic [bbb_pkg::ACT_W-1:0]                    action_index,
  output logic signed [bbb_pkg::VAL_W-1:0]             q_lower,
  output logic signed [bbb_pkg::VAL_W-1:0]             q_upper,
  output logic                                         node_done,
  output logic signed [bbb_pkg::VAL_W-1:0]             node_lower,
  output logic signed [bbb_pkg::VAL_W-1:0]             node_upper,
  output logic signed [bbb_pkg::ACT_W:0]               best_action
);

  bbb_pkg::cmd_t    cmd;
  bbb_pkg::status_t status;

  // sequencer: owns the input handshake and the step order
  bbb_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .outcome_present (outcome_present),
    .last_outcome    (last_outcome),
    .in_ready        (in_ready),
    .status          (status),
    .cmd             (cmd)
  );

  // datapath: registers, multiplier, saturation and the output register
  bbb_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outcome_prob   (outcome_prob),
    .next_lower     (next_lower),
    .next_upper     (next_upper),
    .last_outcome   (last_outcome),
    .action_reward  (action_reward),
    .last_action    (last_action),
    .node_old_lower (node_old_lower),
    .node_old_upper (node_old_upper),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .action_index   (action_index),
    .q_lower        (q_lower),
    .q_upper        (q_upper),
    .node_done      (node_done),
    .node_lower     (node_lower),
    .node_upper     (node_upper),
    .best_action    (best_action)
  );

endmodule
`default_nettype wire

### rtl/bbb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbb_checker
// port-level checks for the bellman backup block, bound to the top level
// ----------------------------------------------------------------------------
module bbb_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               last_outcome,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic                               node_done,
  input wire logic signed [bbb_pkg::VAL_W-1:0]   node_lower,
  input wire logic signed [bbb_pkg::VAL_W-1:0]   node_upper,
  input wire logic signed [bbb_pkg::ACT_W:0]     best_action,
  input wire logic signed [bbb_pkg::VAL_W-1:0]   q_upper
);

  // a final edge always keeps the block busy for the next cycle
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_outcome) |=> !in_ready)
    else $error("input taken right after a final edge");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(q_upper) && $stable(node_done)))
    else $error("stalled result changed");

  // node fields are zero outside node end
  a_node_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !node_done) |-> (node_lower == '0 && node_upper == '0 && best_action == '0))
    else $error("node fields set on a non-final action");

  // no argmax means the upper bound stayed at the minimum
  a_no_best: assert property (@(posedge clk) disable iff (rst)
    (out_valid && node_done && best_action == '1) |-> (node_upper == bbb_pkg::VAL_MIN))
    else $error("node upper not at minimum without argmax");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bellman_bound_backup bbb_checker u_bbb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .last_outcome (last_outcome),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .node_done    (node_done),
  .node_lower   (node_lower),
  .node_upper   (node_upper),
  .best_action  (best_action),
  .q_upper      (q_upper)
);
`default_nettype wire

### test/tb_bellman_bound_backup.sv
// ----------------------------------------------------------------------------
// tb_bellman_bound_backup
// self-checking testbench for the interval bellman backup block
// ----------------------------------------------------------------------------
// Outcome edges are sent one word at a time. Every accepted word goes through
// a local model of the backup: saturating products into the two sums, the
// discounted q values, and the running best bounds. Each result word is
// compared field by field with the oldest predicted backup. A short directed
// part covers the extremes and the corner cases. A run of heavy edges then
// builds sums far beyond the q range. Random traffic follows under three idle
// patterns and several register settings, and between its runs a node of
// more than 256 actions wraps the action count.
// ----------------------------------------------------------------------------
module tb_bellman_bound_backup;
  timeunit 1ns;
  timeprecision 1ps;

  import bbb_pkg::*;

  // cycles allowed for the sequencer to finish a word that gives no result
  localparam int SETTLE_CYCLES = 24;
  localparam logic signed [VAL_W-1:0] ONE = 32'sh0001_0000;

  // one outcome edge as it goes into the block
  typedef struct {
    logic [PROB_W-1:0]       prob;
    logic                    present;
    logic signed [VAL_W-1:0] nxt_lo;
    logic signed [VAL_W-1:0] nxt_hi;
    logic                    last_out;
    logic signed [VAL_W-1:0] reward;
    logic                    last_act;
    logic signed [VAL_W-1:0] old_lo;
    logic signed [VAL_W-1:0] old_hi;
  } outcome_t;

  // one predicted result word
  typedef struct {
    logic [ACT_W-1:0]        act;
    logic signed [VAL_W-1:0] q_lo;
    logic signed [VAL_W-1:0] q_hi;
    logic                    done;
    logic signed [VAL_W-1:0] bound_lo;
    logic signed [VAL_W-1:0] bound_hi;
    logic signed [ACT_W:0]   best;
  } backup_t;

  // clock and block inputs, all known from time zero
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic [PROB_W-1:0]       outcome_prob = '0;
  logic                    outcome_present = 1'b0;
  logic signed [VAL_W-1:0] next_lower = '0;
  logic signed [VAL_W-1:0] next_upper = '0;
  logic                    last_outcome = 1'b0;
  logic signed [VAL_W-1:0] action_reward = '0;
  logic                    last_action = 1'b0;
  logic signed [VAL_W-1:0] node_old_lower = '0;
  logic signed [VAL_W-1:0] node_old_upper = '0;
  logic                    out_ready = 1'b0;

  // block outputs
  logic                    in_ready;
  logic                    out_valid;
  logic [ACT_W-1:0]        action_index;
  logic signed [VAL_W-1:0] q_lower;
  logic signed [VAL_W-1:0] q_upper;
  logic                    node_done;
  logic signed [VAL_W-1:0] node_lower;
  logic signed [VAL_W-1:0] node_upper;
  logic signed [ACT_W:0]   best_action;

  // local copy of the registers
  logic [PROB_W-1:0] disc_q16 = DISCOUNT_RESET;
  logic              lower_on = 1'b1;

  // local copy of the node state
  longint                  acc_lo;
  longint                  acc_hi;
  logic [ACT_W-1:0]        action_no;
  logic signed [VAL_W-1:0] top_lo;
  logic signed [VAL_W-1:0] top_hi;
  logic signed [ACT_W:0]   top_hi_action;

  // predicted backups still waiting for their result word
  backup_t awaited_backups[$];

  // idle percentages for the two sides
  int sender_gap_pct = 12;
  int receiver_stall_pct = 54;

  // run statistics
  int  words_sent = 0;
  int  results_checked = 0;
  int  nodes_checked = 0;
  int  mismatches = 0;
  bit  wrap_seen = 1'b0;

  bellman_bound_backup dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .outcome_prob   (outcome_prob),
    .outcome_present(outcome_present),
    .next_lower     (next_lower),
    .next_upper     (next_upper),
    .last_outcome   (last_outcome),
    .action_reward  (action_reward),
    .last_action    (last_action),
    .node_old_lower (node_old_lower),
    .node_old_upper (node_old_upper),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .action_index   (action_index),
    .q_lower        (q_lower),
    .q_upper        (q_upper),
    .node_done      (node_done),
    .node_lower     (node_lower),
    .node_upper     (node_upper),
    .best_action    (best_action)
  );

  // 100 MHz
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  function automatic void clear_node_state();
    acc_lo = 0;
    acc_hi = 0;
    action_no = '0;
    top_lo = VAL_MIN;
    top_hi = VAL_MIN;
    top_hi_action = '1;
  endfunction

  // 64-bit sum that sticks at the rails instead of wrapping
  function automatic longint add_clamped(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  // reward + floor(sum * discount / 2^32), clipped to the value range
  function automatic logic signed [VAL_W-1:0] discounted_q(
    input longint acc,
    input logic signed [VAL_W-1:0] reward
  );
    logic signed [81:0] wide;
    longint q;
    wide = acc * $signed({1'b0, disc_q16});
    q = longint'(wide >>> 32) + longint'(reward);
    if (q > longint'(VAL_MAX)) return VAL_MAX;
    if (q < longint'(VAL_MIN)) return VAL_MIN;
    return q[VAL_W-1:0];
  endfunction

  task automatic predict_backup(input outcome_t w);
    backup_t r;
    logic [ACT_W-1:0] idx;
    if (w.present) begin
      if (lower_on) acc_lo = add_clamped(acc_lo, longint'(w.prob) * longint'(w.nxt_lo));
      acc_hi = add_clamped(acc_hi, longint'(w.prob) * longint'(w.nxt_hi));
    end
    if (!w.last_out) return;

    r = '{default: '0};
    idx = action_no;
    r.act = idx;
    r.q_hi = discounted_q(acc_hi, w.reward);
    if (lower_on) begin
      r.q_lo = discounted_q(acc_lo, w.reward);
      if (r.q_lo > top_lo) top_lo = r.q_lo;
    end
    // strict compare: the first action reaching a value keeps the argmax
    if (r.q_hi > top_hi) begin
      top_hi = r.q_hi;
      top_hi_action = {1'b0, idx};
    end
    acc_lo = 0;
    acc_hi = 0;
    if (idx == ACT_W'(MAX_ACTIONS - 1)) begin
      action_no = '0;
      wrap_seen = 1'b1;
    end else begin
      action_no = idx + 1'b1;
    end

    if (w.last_act) begin
      r.done = 1'b1;
      if (!lower_on) r.bound_lo = w.old_lo;
      else r.bound_lo = (w.old_lo > top_lo) ? w.old_lo : top_lo;
      r.bound_hi = (w.old_hi < top_hi) ? w.old_hi : top_hi;
      r.best = top_hi_action;
      clear_node_state();
    end
    awaited_backups.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // receiver stalls at random, changed on the falling edge
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  // every accepted result word is matched against the oldest prediction
  always @(posedge clk) begin : check_results
    backup_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_backups.size() == 0) begin
        $error("result word with no backup pending: action_index %0d", action_index);
        mismatches++;
      end else begin
        want = awaited_backups.pop_front();
        check_field("action_index", want.act, action_index);
        check_field("q_lower", want.q_lo, q_lower);
        check_field("q_upper", want.q_hi, q_upper);
        check_field("node_done", want.done, node_done);
        check_field("node_lower", want.bound_lo, node_lower);
        check_field("node_upper", want.bound_hi, node_upper);
        check_field("best_action", want.best, best_action);
        results_checked++;
        if (want.done) nodes_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // offers one word, waits for the handshake, then predicts it
  task automatic send_outcome(input outcome_t w);
    while ($urandom_range(99) < sender_gap_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    outcome_prob = w.prob;
    outcome_present = w.present;
    next_lower = w.nxt_lo;
    next_upper = w.nxt_hi;
    last_outcome = w.last_out;
    action_reward = w.reward;
    last_action = w.last_act;
    node_old_lower = w.old_lo;
    node_old_upper = w.old_hi;
    do @(posedge clk); while (!in_ready);
    predict_backup(w);
    words_sent++;
  endtask

  // sender holds off until every pending backup has come out
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_backups.size() != 0) @(negedge clk);
  endtask

  // drained and then some, so a word with no result has also finished
  task automatic let_block_settle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(
    input logic [CFG_IDX_W-1:0] idx,
    input logic [CFG_DATA_W-1:0] data
  );
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_DISCOUNT: disc_q16 = data;
      REG_LOWER_EN: lower_on = data[0];
      default: ;
    endcase
  endtask

  function automatic outcome_t make_word(
    input logic [PROB_W-1:0] prob,
    input logic present,
    input logic signed [VAL_W-1:0] nxt_lo,
    input logic signed [VAL_W-1:0] nxt_hi,
    input logic last_out,
    input logic signed [VAL_W-1:0] reward,
    input logic last_act,
    input logic signed [VAL_W-1:0] old_lo,
    input logic signed [VAL_W-1:0] old_hi
  );
    outcome_t w;
    w.prob = prob;
    w.present = present;
    w.nxt_lo = nxt_lo;
    w.nxt_hi = nxt_hi;
    w.last_out = last_out;
    w.reward = reward;
    w.last_act = last_act;
    w.old_lo = old_lo;
    w.old_hi = old_hi;
    return w;
  endfunction

  // mostly rails, zero and small values, the rest anything at all
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3, 4, 5: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
      default: return $urandom;
    endcase
  endfunction

  function automatic outcome_t random_word();
    outcome_t w;
    w.prob = PROB_W'($urandom);
    w.present = 1'($urandom_range(1));
    w.nxt_lo = rand_value();
    w.nxt_hi = rand_value();
    w.last_out = 1'($urandom_range(1));
    w.reward = rand_value();
    w.last_act = 1'($urandom_range(1));
    w.old_lo = rand_value();
    w.old_hi = rand_value();
    return w;
  endfunction

  // a node of a few actions, probabilities roughly summing to one; now and
  // then a stray last-action flag or a missing one that runs into the next
  task automatic send_random_node();
    outcome_t w;
    int n_act;
    int n_out;
    int unsigned left;
    int unsigned share;
    n_act = $urandom_range(1, 6);
    for (int a = 0; a < n_act; a++) begin
      n_out = $urandom_range(1, 5);
      left = 65536;
      for (int o = 0; o < n_out; o++) begin
        w = random_word();
        w.present = ($urandom_range(9) != 0);
        share = (o == n_out - 1) ? left : $urandom_range(0, left);
        left -= share;
        w.prob = PROB_W'(share);
        if ($urandom_range(19) == 0) w.prob = PROB_W'($urandom);
        w.last_out = (o == n_out - 1);
        if (w.last_out) w.last_act = (a == n_act - 1) && ($urandom_range(19) != 0);
        else w.last_act = ($urandom_range(19) == 0);
        send_outcome(w);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset discount, lower bound on: two actions, an absent edge, a stray flag
  task automatic test_reset_node();
    send_outcome(make_word(17'd32768, 1'b1, 2 * ONE, 3 * ONE, 1'b0, '0, 1'b0, '0, '0));
    // last action without last outcome is ignored
    send_outcome(make_word(17'd1000, 1'b1, VAL_MAX, VAL_MAX, 1'b0, '0, 1'b1, '0, '0));
    send_outcome(make_word(17'd32768, 1'b1, -ONE, 5 * ONE, 1'b1, ONE, 1'b0, '0, '0));
    // absent edge adds nothing however large its values
    send_outcome(make_word(17'd65536, 1'b0, VAL_MAX, VAL_MAX, 1'b1, -32'sd32768, 1'b1,
                           VAL_MIN, VAL_MAX));
  endtask

  // q clipping at both rails, floor rounding of a tiny negative sum, and old
  // node bounds that win over the best q values
  task automatic test_saturation_and_rounding();
    send_outcome(make_word(17'h1FFFF, 1'b1, VAL_MAX, VAL_MAX, 1'b1, VAL_MAX, 1'b0, '0, '0));
    send_outcome(make_word(17'd1, 1'b1, -32'sd1, -32'sd1, 1'b1, '0, 1'b0, '0, '0));
    send_outcome(make_word(17'd65536, 1'b1, VAL_MIN, VAL_MIN, 1'b1, VAL_MIN, 1'b0, '0, '0));
    send_outcome(make_word(17'd40000, 1'b1, 32'sd12345, -32'sd777, 1'b1, -32'sd3, 1'b1,
                           VAL_MAX, VAL_MIN));
  endtask

  // no q above the minimum gives no argmax; equal q values keep the first
  task automatic test_no_best_action();
    send_outcome(make_word('0, 1'b0, ONE, ONE, 1'b1, VAL_MIN, 1'b0, '0, '0));
    send_outcome(make_word(17'd65536, 1'b0, ONE, ONE, 1'b1, VAL_MIN, 1'b1,
                           32'sh1234, VAL_MAX));
    send_outcome(make_word('0, 1'b1, ONE, ONE, 1'b1, 5 * ONE, 1'b0, '0, '0));
    send_outcome(make_word('0, 1'b1, -ONE, -ONE, 1'b1, 5 * ONE, 1'b1, VAL_MIN, VAL_MAX));
  endtask

  // upper bound only, unit discount; old lower bound must pass straight through
  task automatic test_lower_disabled();
    let_block_settle();
    write_register(REG_LOWER_EN, 17'h1FFFE);
    write_register(REG_DISCOUNT, 17'd65536);
    send_outcome(make_word(17'd20000, 1'b1, VAL_MIN, 7 * ONE, 1'b0, '0, 1'b0, '0, '0));
    send_outcome(make_word(17'd45536, 1'b1, VAL_MAX, -2 * ONE, 1'b1, ONE, 1'b0, '0, '0));
    send_outcome(make_word(17'd65536, 1'b1, 3 * ONE, 3 * ONE, 1'b1, '0, 1'b1,
                           -32'sd7, 100 * ONE));
  endtask

  // discount of zero, all ones (above one) and exactly one
  task automatic test_discount_extremes();
    let_block_settle();
    write_register(REG_LOWER_EN, 17'h1FFFF);
    write_register(REG_DISCOUNT, '0);
    send_outcome(make_word(17'd65536, 1'b1, ONE, -ONE, 1'b1, -32'sd5, 1'b1, VAL_MIN, VAL_MAX));
    let_block_settle();
    write_register(REG_DISCOUNT, 17'h1FFFF);
    send_outcome(make_word(17'h1FFFF, 1'b1, VAL_MAX, VAL_MIN, 1'b1, '0, 1'b1, '0, '0));
    let_block_settle();
    write_register(REG_DISCOUNT, 17'd65536);
    send_outcome(make_word(17'd65536, 1'b1, -ONE, ONE, 1'b1, ONE, 1'b1, -ONE, ONE));
  endtask

  // build both sums far past the q range, then step back by one small edge;
  // both q values must clip, not wrap
  task automatic test_sum_saturation();
    let_block_settle();
    write_register(REG_DISCOUNT, DISCOUNT_RESET);
    write_register(REG_LOWER_EN, 17'd1);
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    repeat (16) begin
      send_outcome(make_word(17'h1FFFF, 1'b1, VAL_MIN, VAL_MAX, 1'b0, '0, 1'b0, '0, '0));
    end
    send_outcome(make_word(17'd1, 1'b1, VAL_MAX, VAL_MIN, 1'b0, '0, 1'b0, '0, '0));
    send_outcome(make_word('0, 1'b0, '0, '0, 1'b1, '0, 1'b1, VAL_MIN, VAL_MAX));
  endtask

  // one node with more actions than the counter holds
  task automatic test_action_wrap();
    outcome_t w;
    for (int a = 0; a < MAX_ACTIONS + 3; a++) begin
      w = random_word();
      w.last_out = 1'b1;
      w.last_act = (a == MAX_ACTIONS + 2);
      send_outcome(w);
    end
  endtask

  // random nodes with a little noise and the odd full drain
  task automatic test_random_traffic(
    input int n_words,
    input int gap_pct,
    input int stall_pct,
    input logic [PROB_W-1:0] disc,
    input logic lb_on
  );
    int first;
    int pick;
    outcome_t w;
    let_block_settle();
    write_register(REG_DISCOUNT, disc);
    write_register(REG_LOWER_EN, {16'($urandom), lb_on});
    sender_gap_pct = gap_pct;
    receiver_stall_pct = stall_pct;
    first = words_sent;
    while (words_sent - first < n_words) begin
      pick = $urandom_range(99);
      if (pick < 2) pause_until_drained();
      else if (pick < 12) send_outcome(random_word());
      else send_random_node();
    end
    // close whatever node is still open before the registers change
    w = random_word();
    w.last_out = 1'b1;
    w.last_act = 1'b1;
    send_outcome(w);
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    clear_node_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_node();
    test_saturation_and_rounding();
    test_no_best_action();
    test_lower_disabled();
    test_discount_extremes();
    test_sum_saturation();

    // sender gaps light, receiver stalls heavy
    test_random_traffic(330, 12, 54, 17'($urandom_range(0, 65536)), 1'b1);
    test_action_wrap();
    // the other way round, upper bound only
    test_random_traffic(330, 54, 12, 17'($urandom_range(0, 65536)), 1'b0);
    // full rate both sides
    test_random_traffic(330, 0, 0, 17'd65536, 1'b1);

    let_block_settle();
    $display("sent %0d outcome words, checked %0d action results, %0d of them node ends",
             words_sent, results_checked, nodes_checked);
    $display("discount 0 to above one, lower bound on and off, large sums, counter wrap %s",
             wrap_seen ? "seen" : "missed");
    if (mismatches == 0 && awaited_backups.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### bellman_bound_backup.f
rtl/bbb_pkg.sv
rtl/bbb_ctrl.sv
rtl/bbb_dp.sv
rtl/bellman_bound_backup.sv
rtl/bbb_checker.sv
test/tb_bellman_bound_backup.sv
